// ----- rtl/tcw_pkg.sv -----
// Shared types and constants for the text console writer.
// Screen geometry, control codes, command and status structs, sequencer states.
// No dependencies.
`default_nettype none

package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    // Field widths
    localparam int IDX_W      = 11;
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int CHAR_W     = 8;
    localparam int CELL_W     = 16;
    localparam int COLOR_W    = 4;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 4;

    // Command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Cell written into cleared and scrolled-in rows
    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F00;

    // Character codes
    localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_RETURN  = 8'd13;
    localparam logic [CHAR_W-1:0] CODE_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CODE_SPACE   = 8'd32;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_TEXT_COLOR       = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_BACKGROUND_COLOR = 1'b1;

    // Classified operations
    typedef enum logic [2:0] {
        OP_PUT,
        OP_TAB,
        OP_NEWLINE,
        OP_RETURN,
        OP_READ,
        OP_VOID
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] code;
        logic [IDX_W-1:0]  index;
    } cmd_t;

    typedef struct packed {
        logic [COLOR_W-1:0] bg;
        logic [COLOR_W-1:0] fg;
    } colours_t;

    typedef struct packed {
        logic clearing;
        logic scrolling;
    } back_status_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PUT,
        ST_RDWAIT,
        ST_SCROLL,
        ST_FILL,
        ST_DONE
    } back_state_t;

endpackage

`default_nettype wire

// ----- rtl/text_console_writer_unit.sv -----
// Top level of the text console writer: colour registers, front end, queue, back end.
// Depends on tcw_pkg, tcw_front, tcw_queue and tcw_back.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    s_action, s_character, s_cell_index
//   m_        out        m_valid/m_ready    m_cursor_position, m_cell_value, m_scrolled
//   cfg_      in         cfg_wr_en          cfg_index, cfg_data
//
// With the back end idle, a printable character passes ST_PUT then ST_DONE, a read ST_RDWAIT
// then ST_DONE, a return, plain newline or read past the screen only ST_DONE, and a tab ST_PUT
// four times. A scroll adds 1920 row copies, one last write-back and 80 blank fills.
// After reset a clearing pass writes all 2000 cells, one a cycle; s_ready stays low meanwhile.
// The back end starts an item only while the result register is empty; the
// two-entry queue keeps accepting items until full while it works or while m_ready is low.
`default_nettype none

module text_console_writer_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_action,
    input  wire logic [tcw_pkg::CHAR_W-1:0]      s_character,
    input  wire logic [tcw_pkg::IDX_W-1:0]       s_cell_index,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [tcw_pkg::IDX_W-1:0]            m_cursor_position,
    output logic [tcw_pkg::CELL_W-1:0]           m_cell_value,
    output logic                                 m_scrolled,
    input  wire logic                            cfg_wr_en,
    input  wire logic [tcw_pkg::CFG_ADDR_W-1:0]  cfg_index,
    input  wire logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [tcw_pkg::COLOR_W-1:0] text_color_reg;
    logic [tcw_pkg::COLOR_W-1:0] background_color_reg;
    tcw_pkg::colours_t           colours;
    tcw_pkg::back_status_t       status;
    tcw_pkg::cmd_t               push_cmd, head_cmd;
    logic                        push, q_full, head_valid, pop;

    // Colour registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_color_reg       <= tcw_pkg::COLOR_W'(15);
            background_color_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                tcw_pkg::REG_TEXT_COLOR:       text_color_reg       <= cfg_data;
                tcw_pkg::REG_BACKGROUND_COLOR: background_color_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign colours.fg = text_color_reg;
    assign colours.bg = background_color_reg;

    tcw_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_character  (s_character),
        .s_cell_index (s_cell_index),
        .status       (status),
        .q_full       (q_full),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    tcw_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    tcw_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .colours           (colours),
        .q_valid           (head_valid),
        .q_cmd             (head_cmd),
        .pop               (pop),
        .status            (status),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_cursor_position (m_cursor_position),
        .m_cell_value      (m_cell_value),
        .m_scrolled        (m_scrolled)
    );

`ifndef SYNTH
    // No item enters while the screen is being cleared
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        status.clearing |-> !s_ready)
        else $error("item accepted during clearing pass");

    // A scroll only starts once the previous result has gone
    a_no_result_in_scroll: assert property (@(posedge aclk) disable iff (!aresetn)
        status.scrolling |-> !m_valid)
        else $error("result pending during scroll");

    // A scrolled result leaves the cursor on the bottom row
    a_scroll_bottom_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_scrolled) |->
            (m_cursor_position >= tcw_pkg::IDX_W'((tcw_pkg::ROWS-1) * tcw_pkg::COLUMNS)))
        else $error("scroll left cursor off the bottom row");

    // A read never scrolls
    a_read_no_scroll: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_cell_value != '0)) |-> !m_scrolled)
        else $error("result with cell value also flags scroll");
`endif

endmodule

`default_nettype wire

// ----- rtl/tcw_front.sv -----
// Front end: accepts input items and classifies them into console commands.
// Depends on tcw_pkg; feeds tcw_queue.
`default_nettype none

module tcw_front (
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_action,
    input  wire logic [tcw_pkg::CHAR_W-1:0]  s_character,
    input  wire logic [tcw_pkg::IDX_W-1:0]   s_cell_index,
    input  wire tcw_pkg::back_status_t       status,
    input  wire logic                        q_full,
    output logic                             push,
    output tcw_pkg::cmd_t                    push_cmd
);

    // Stall while the queue is full or the screen is being cleared
    assign s_ready = !q_full && !status.clearing;
    assign push    = s_valid && s_ready;

    // Decode the item into one command
    always_comb begin
        push_cmd.code  = s_character;
        push_cmd.index = s_cell_index;
        if (s_action) begin
            if (s_cell_index < tcw_pkg::IDX_W'(tcw_pkg::CELLS)) begin
                push_cmd.op = tcw_pkg::OP_READ;
            end else begin
                push_cmd.op = tcw_pkg::OP_VOID;
            end
        end else begin
            unique case (s_character)
                tcw_pkg::CODE_NEWLINE: push_cmd.op = tcw_pkg::OP_NEWLINE;
                tcw_pkg::CODE_RETURN:  push_cmd.op = tcw_pkg::OP_RETURN;
                tcw_pkg::CODE_TAB:     push_cmd.op = tcw_pkg::OP_TAB;
                default:               push_cmd.op = tcw_pkg::OP_PUT;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tcw_queue.sv -----
// Short command queue between the front end and the back end.
// Depends on tcw_pkg.
`default_nettype none

module tcw_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire tcw_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output tcw_pkg::cmd_t      head_cmd
);

    tcw_pkg::cmd_t                entries_reg [tcw_pkg::QUEUE_DEPTH];
    logic [tcw_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [tcw_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [tcw_pkg::QPTR_W:0]     count_reg, count_next;
    logic                         do_pop;

    assign full       = count_reg == (tcw_pkg::QPTR_W+1)'(tcw_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = entries_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // Advance pointers with explicit wrap
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == tcw_pkg::QPTR_W'(tcw_pkg::QUEUE_DEPTH-1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == tcw_pkg::QPTR_W'(tcw_pkg::QUEUE_DEPTH-1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tcw_back.sv -----
// Back end: screen memory, cursor and the sequencer that carries out commands.
// Holds the result register. Depends on tcw_pkg; takes commands from tcw_queue.
`default_nettype none

module tcw_back (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire tcw_pkg::colours_t          colours,
    input  wire logic                       q_valid,
    input  wire tcw_pkg::cmd_t              q_cmd,
    output logic                            pop,
    output tcw_pkg::back_status_t           status,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [tcw_pkg::IDX_W-1:0]       m_cursor_position,
    output logic [tcw_pkg::CELL_W-1:0]      m_cell_value,
    output logic                            m_scrolled
);

    localparam logic [tcw_pkg::IDX_W-1:0] LAST_CELL  = tcw_pkg::IDX_W'(tcw_pkg::CELLS-1);
    localparam logic [tcw_pkg::IDX_W-1:0] ROW_STEP   = tcw_pkg::IDX_W'(tcw_pkg::COLUMNS);
    localparam logic [tcw_pkg::IDX_W-1:0] BOTTOM_ROW =
        tcw_pkg::IDX_W'((tcw_pkg::ROWS-1) * tcw_pkg::COLUMNS);

    // Screen memory
    logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELLS];
    logic                       mem_we, mem_re;
    logic [tcw_pkg::IDX_W-1:0]  mem_wa, mem_ra;
    logic [tcw_pkg::CELL_W-1:0] mem_wd;
    logic [tcw_pkg::CELL_W-1:0] rd_data_reg;

    tcw_pkg::back_state_t       state_reg, state_next;
    logic [tcw_pkg::IDX_W-1:0]  cnt_reg, cnt_next;
    logic [tcw_pkg::COL_W-1:0]  col_reg, col_next;
    logic [tcw_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [tcw_pkg::IDX_W-1:0]  base_reg, base_next;
    logic [1:0]                 rep_reg, rep_next;
    logic                       pend_reg, pend_next;
    logic [tcw_pkg::IDX_W-1:0]  wa_reg, wa_next;
    logic [tcw_pkg::CHAR_W-1:0] code_reg, code_next;
    logic [tcw_pkg::CELL_W-1:0] value_reg, value_next;
    logic                       scrolled_reg, scrolled_next;
    logic                       out_valid_reg, out_valid_next;
    logic [tcw_pkg::IDX_W-1:0]  out_pos_reg, out_pos_next;
    logic [tcw_pkg::CELL_W-1:0] out_value_reg, out_value_next;
    logic                       out_scrolled_reg, out_scrolled_next;

    logic col_last, row_last, take;

    assign col_last = col_reg == tcw_pkg::COL_W'(tcw_pkg::COLUMNS-1);
    assign row_last = row_reg == tcw_pkg::ROW_W'(tcw_pkg::ROWS-1);
    assign take     = q_valid && !out_valid_reg;

    assign status.clearing  = state_reg == tcw_pkg::ST_CLEAR;
    assign status.scrolling = (state_reg == tcw_pkg::ST_SCROLL) ||
                              (state_reg == tcw_pkg::ST_FILL);

    assign m_valid           = out_valid_reg;
    assign m_cursor_position = out_pos_reg;
    assign m_cell_value      = out_value_reg;
    assign m_scrolled        = out_scrolled_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tcw_pkg::ST_CLEAR: begin
                if (cnt_reg == LAST_CELL) begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE: begin
                if (take) begin
                    unique case (q_cmd.op)
                        tcw_pkg::OP_PUT,
                        tcw_pkg::OP_TAB:     state_next = tcw_pkg::ST_PUT;
                        tcw_pkg::OP_NEWLINE: state_next = row_last ? tcw_pkg::ST_SCROLL :
                                                                     tcw_pkg::ST_DONE;
                        tcw_pkg::OP_READ:    state_next = tcw_pkg::ST_RDWAIT;
                        default:             state_next = tcw_pkg::ST_DONE;
                    endcase
                end
            end
            tcw_pkg::ST_PUT: begin
                if (col_last && row_last) begin
                    state_next = tcw_pkg::ST_SCROLL;
                end else if (rep_reg == '0) begin
                    state_next = tcw_pkg::ST_DONE;
                end
            end
            tcw_pkg::ST_RDWAIT: state_next = tcw_pkg::ST_DONE;
            tcw_pkg::ST_SCROLL: begin
                if (cnt_reg == LAST_CELL) begin
                    state_next = tcw_pkg::ST_FILL;
                end
            end
            tcw_pkg::ST_FILL: begin
                if (!pend_reg && cnt_reg == LAST_CELL) begin
                    state_next = (rep_reg != '0) ? tcw_pkg::ST_PUT : tcw_pkg::ST_DONE;
                end
            end
            tcw_pkg::ST_DONE: state_next = tcw_pkg::ST_IDLE;
            default:          state_next = tcw_pkg::ST_IDLE;
        endcase
    end

    // Datapath, memory port and result register control
    always_comb begin
        cnt_next          = cnt_reg;
        col_next          = col_reg;
        row_next          = row_reg;
        base_next         = base_reg;
        rep_next          = rep_reg;
        pend_next         = 1'b0;
        wa_next           = cnt_reg - ROW_STEP;
        code_next         = code_reg;
        value_next        = value_reg;
        scrolled_next     = scrolled_reg;
        out_valid_next    = out_valid_reg;
        out_pos_next      = out_pos_reg;
        out_value_next    = out_value_reg;
        out_scrolled_next = out_scrolled_reg;
        mem_we            = 1'b0;
        mem_wa            = cnt_reg;
        mem_wd            = tcw_pkg::BLANK_CELL;
        mem_re            = 1'b0;
        mem_ra            = cnt_reg;
        pop               = 1'b0;

        // Drop the result once taken
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            tcw_pkg::ST_CLEAR: begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            tcw_pkg::ST_IDLE: begin
                if (take) begin
                    pop           = 1'b1;
                    scrolled_next = 1'b0;
                    value_next    = '0;
                    code_next     = q_cmd.code;
                    rep_next      = '0;
                    unique case (q_cmd.op)
                        tcw_pkg::OP_TAB: begin
                            code_next = tcw_pkg::CODE_SPACE;
                            rep_next  = 2'd3;
                        end
                        tcw_pkg::OP_NEWLINE: begin
                            col_next = '0;
                            if (row_last) begin
                                scrolled_next = 1'b1;
                                cnt_next      = ROW_STEP;
                            end else begin
                                row_next  = row_reg + 1'b1;
                                base_next = base_reg + ROW_STEP;
                            end
                        end
                        tcw_pkg::OP_RETURN: col_next = '0;
                        tcw_pkg::OP_READ: begin
                            mem_re = 1'b1;
                            mem_ra = q_cmd.index;
                        end
                        default: ;
                    endcase
                end
            end
            tcw_pkg::ST_PUT: begin
                // Write the cell under the cursor, then advance
                mem_we = 1'b1;
                mem_wa = base_reg + tcw_pkg::IDX_W'(col_reg);
                mem_wd = {colours.bg, colours.fg, code_reg};
                if (col_last) begin
                    col_next = '0;
                    if (row_last) begin
                        scrolled_next = 1'b1;
                        cnt_next      = ROW_STEP;
                    end else begin
                        row_next  = row_reg + 1'b1;
                        base_next = base_reg + ROW_STEP;
                    end
                end else begin
                    col_next = col_reg + 1'b1;
                end
                if (!(col_last && row_last) && rep_reg != '0) begin
                    rep_next = rep_reg - 1'b1;
                end
            end
            tcw_pkg::ST_RDWAIT: value_next = rd_data_reg;
            tcw_pkg::ST_SCROLL: begin
                // Read one row down, write it back in the next cycle
                mem_re    = 1'b1;
                pend_next = 1'b1;
                if (pend_reg) begin
                    mem_we = 1'b1;
                    mem_wa = wa_reg;
                    mem_wd = rd_data_reg;
                end
                cnt_next = (cnt_reg == LAST_CELL) ? BOTTOM_ROW : cnt_reg + 1'b1;
            end
            tcw_pkg::ST_FILL: begin
                mem_we = 1'b1;
                if (pend_reg) begin
                    mem_wa = wa_reg;
                    mem_wd = rd_data_reg;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == LAST_CELL && rep_reg != '0) begin
                        rep_next = rep_reg - 1'b1;
                    end
                end
            end
            tcw_pkg::ST_DONE: begin
                out_valid_next    = 1'b1;
                out_pos_next      = base_reg + tcw_pkg::IDX_W'(col_reg);
                out_value_next    = value_reg;
                out_scrolled_next = scrolled_reg;
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tcw_pkg::ST_CLEAR;
            cnt_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= tcw_pkg::ROW_W'(tcw_pkg::ROWS-1);
            base_reg      <= BOTTOM_ROW;
            rep_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            base_reg      <= base_next;
            rep_reg       <= rep_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        wa_reg           <= wa_next;
        code_reg         <= code_next;
        value_reg        <= value_next;
        scrolled_reg     <= scrolled_next;
        out_pos_reg      <= out_pos_next;
        out_value_reg    <= out_value_next;
        out_scrolled_reg <= out_scrolled_next;
    end

    // Screen memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_ra];
        end
    end

endmodule

`default_nettype wire

// ----- sim/tcw_test_pkg.sv -----
// Testbench codes for the text console writer: the item action values.
// Shared by the console checker and the test top; no dependencies.
`timescale 1ns / 1ps

package tcw_test_pkg;

    // Action carried by each input item
    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_READ  = 1'b1
    } console_action_t;

endpackage

// ----- sim/console_result_checker.sv -----
// Console checker: keeps a shadow screen, cursor and colours, predicts every result
// item and compares it with what the writer returns. Depends on tcw_pkg, tcw_test_pkg.
`timescale 1ns / 1ps

module console_result_checker
    import tcw_pkg::*;
    import tcw_test_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    input  wire logic                  s_ready,
    input  wire logic                  s_action,
    input  wire logic [CHAR_W-1:0]     s_character,
    input  wire logic [IDX_W-1:0]      s_cell_index,
    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    input  wire logic [IDX_W-1:0]      m_cursor_position,
    input  wire logic [CELL_W-1:0]     m_cell_value,
    input  wire logic                  m_scrolled,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         outstanding,
    output int                         mismatches
);

    typedef struct {
        logic [IDX_W-1:0]  cursor;
        logic [CELL_W-1:0] cell_value;
        logic              scrolled;
    } cursor_report_t;

    // Shadow of the console state
    logic [CELL_W-1:0]  shadow_cells [0:CELLS-1];
    int unsigned        shadow_col;
    int unsigned        shadow_row;
    logic [COLOR_W-1:0] shadow_fg;
    logic [COLOR_W-1:0] shadow_bg;

    cursor_report_t predicted_reports [$];
    int             error_total = 0;

    function automatic void clear_shadow();
        for (int i = 0; i < CELLS; i++) shadow_cells[i] = BLANK_CELL;
        shadow_col = 0;
        shadow_row = ROWS - 1;
        shadow_fg  = 4'hF;
        shadow_bg  = 4'h0;
    endfunction

    // Move every row up one and blank the bottom row, whatever the colours
    function automatic bit scroll_shadow();
        for (int i = 0; i < CELLS - COLUMNS; i++) shadow_cells[i] = shadow_cells[i + COLUMNS];
        for (int c = 0; c < COLUMNS; c++) shadow_cells[CELLS - COLUMNS + c] = BLANK_CELL;
        return 1'b1;
    endfunction

    // Wrap the column, then scroll if the row has run off the bottom
    function automatic bit settle_cursor();
        bit rolled = 1'b0;
        if (shadow_col >= COLUMNS) begin
            shadow_col = 0;
            shadow_row++;
        end
        if (shadow_row >= ROWS) begin
            shadow_row = ROWS - 1;
            rolled = scroll_shadow();
        end
        return rolled;
    endfunction

    function automatic bit put_glyph(input logic [CHAR_W-1:0] code);
        int unsigned at = shadow_row * COLUMNS + shadow_col;
        if (at < CELLS) shadow_cells[at] = {shadow_bg, shadow_fg, code};
        shadow_col++;
        return settle_cursor();
    endfunction

    // Print one code or obey it; a tab is four spaces, any of which may scroll
    function automatic bit print_code(input logic [CHAR_W-1:0] code);
        bit rolled = 1'b0;
        case (code)
            CODE_NEWLINE: begin
                shadow_col = 0;
                shadow_row++;
                rolled = settle_cursor();
            end
            CODE_RETURN: begin
                shadow_col = 0;
                rolled = settle_cursor();
            end
            CODE_TAB: begin
                for (int i = 0; i < 4; i++) if (put_glyph(CODE_SPACE)) rolled = 1'b1;
            end
            default: begin
                rolled = put_glyph(code);
            end
        endcase
        return rolled;
    endfunction

    function automatic void report_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d (0x%0h), actual %0d (0x%0h)",
                     $time, field, want, want, got, got);
            error_total++;
        end
    endfunction

    always @(posedge aclk) begin : watch
        cursor_report_t want;
        if (!aresetn) begin
            clear_shadow();
            predicted_reports.delete();
        end else begin
            // Compare the returned item with the oldest prediction
            if (m_valid && m_ready) begin
                if (predicted_reports.size() == 0) begin
                    $display({"%0t: unexpected result: expected none, ",
                              "actual cursor %0d cell 0x%0h scrolled %0d"},
                             $time, m_cursor_position, m_cell_value, m_scrolled);
                    error_total++;
                end else begin
                    want = predicted_reports.pop_front();
                    report_field("cursor_position", int'(want.cursor),
                                 int'(m_cursor_position));
                    report_field("cell_value", int'(want.cell_value), int'(m_cell_value));
                    report_field("scrolled", int'(want.scrolled), int'(m_scrolled));
                end
            end
            // Track colour register writes
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_TEXT_COLOR:       shadow_fg = cfg_data;
                    REG_BACKGROUND_COLOR: shadow_bg = cfg_data;
                    default: ;
                endcase
            end
            // Predict the result of each accepted item
            if (s_valid && s_ready) begin
                want.cell_value = '0;
                want.scrolled   = 1'b0;
                if (s_action == ACT_WRITE) begin
                    want.scrolled = print_code(s_character);
                end else if (s_cell_index < CELLS) begin
                    want.cell_value = shadow_cells[s_cell_index];
                end
                want.cursor = IDX_W'(shadow_row * COLUMNS + shadow_col);
                predicted_reports.push_back(want);
            end
        end
        outstanding <= predicted_reports.size();
        mismatches  <= error_total;
    end

endmodule

// ----- sim/text_console_writer_unit_test.sv -----
// Test top for the text console writer: clock, reset, colour writes and item stimulus.
// Depends on tcw_pkg, tcw_test_pkg, console_result_checker and text_console_writer_unit.
`timescale 1ns / 1ps

module text_console_writer_unit_test;
    import tcw_pkg::*;
    import tcw_test_pkg::*;

    localparam int PHASES           = 7;
    localparam int PHASE_ITEMS      = 250;
    localparam int LONG_HOLD_AT     = 700;
    localparam int LONG_HOLD_CYCLES = 600;
    localparam int DRAIN_CAP        = 50000;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic                  s_action     = ACT_WRITE;
    logic [CHAR_W-1:0]     s_character  = '0;
    logic [IDX_W-1:0]      s_cell_index = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [IDX_W-1:0]      m_cursor_position;
    logic [CELL_W-1:0]     m_cell_value;
    logic                  m_scrolled;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_index    = REG_TEXT_COLOR;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    int                    outstanding;
    int                    mismatches;
    bit                    gap_on       = 1'b1;

    always #6 aclk = ~aclk;

    text_console_writer_unit u_dut (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_action, .s_character, .s_cell_index,
        .m_valid, .m_ready, .m_cursor_position, .m_cell_value, .m_scrolled,
        .cfg_wr_en, .cfg_index, .cfg_data
    );

    console_result_checker u_checker (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_action, .s_character, .s_cell_index,
        .m_valid, .m_ready, .m_cursor_position, .m_cell_value, .m_scrolled,
        .cfg_wr_en, .cfg_index, .cfg_data,
        .outstanding, .mismatches
    );

    // Offer one item, after a random gap when gaps are on, and hold it until accepted
    task automatic offer_item(input console_action_t act, input logic [CHAR_W-1:0] code,
                              input logic [IDX_W-1:0] idx);
        int unsigned gap = gap_on ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= act;
        s_character  <= code;
        s_cell_index <= idx;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic print_char(input logic [CHAR_W-1:0] code);
        offer_item(ACT_WRITE, code, IDX_W'($urandom_range(0, 2047)));
    endtask

    task automatic read_cell(input int unsigned idx);
        offer_item(ACT_READ, CHAR_W'($urandom_range(0, 255)), IDX_W'(idx));
    endtask

    // Stop offering and wait until every predicted result has come back or DRAIN_CAP runs out
    task automatic drain_console();
        int unsigned spins = 0;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0 && spins < DRAIN_CAP) begin
            @(posedge aclk);
            spins++;
        end
    endtask

    // Write both colour registers; only while the writer is idle
    task automatic set_colours(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_TEXT_COLOR;
        cfg_data  <= fg;
        @(posedge aclk);
        cfg_index <= REG_BACKGROUND_COLOR;
        cfg_data  <= bg;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly printable text, with reads, control codes and the odd read past the screen
    task automatic random_item();
        int unsigned pick = $urandom_range(0, 99);
        if (pick < 15)      read_cell($urandom_range(0, 2047));
        else if (pick < 30) read_cell($urandom_range(CELLS - 3 * COLUMNS, CELLS - 1));
        else if (pick < 34) print_char(CODE_NEWLINE);
        else if (pick < 37) print_char(CODE_RETURN);
        else if (pick < 42) print_char(CODE_TAB);
        else                print_char(CHAR_W'($urandom_range(0, 255)));
    endtask

    initial begin : stimulus
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset contents, edges of the index, every control code
        read_cell(0);
        read_cell(CELLS - 1);
        read_cell(CELLS);
        read_cell(2047);
        print_char(8'd65);
        read_cell(CELLS - COLUMNS);
        print_char(8'h00);
        print_char(8'hFF);
        print_char(CODE_TAB);
        read_cell(CELLS - COLUMNS + 3);
        print_char(CODE_RETURN);
        print_char(8'd66);
        print_char(CODE_NEWLINE);
        read_cell(CELLS - 2 * COLUMNS);
        read_cell(CELLS - COLUMNS);
        drain_console();

        // Directed: extreme colours, and a scroll that fills with the blank cell
        set_colours(4'h0, 4'hF);
        print_char(8'h5A);
        read_cell(CELLS - COLUMNS);
        print_char(CODE_NEWLINE);
        read_cell(CELLS - COLUMNS);
        read_cell(CELLS - 2 * COLUMNS);
        drain_console();

        // Random phases, each under its own colours, idling on every other one
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin fg = 4'hF; bg = 4'h0; end
                1: begin fg = 4'h0; bg = 4'h0; end
                2: begin fg = 4'hF; bg = 4'hF; end
                default: begin
                    fg = COLOR_W'($urandom_range(0, 15));
                    bg = COLOR_W'($urandom_range(0, 15));
                end
            endcase
            set_colours(fg, bg);
            gap_on = (phase % 2 == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) random_item();
            drain_console();
        end

        repeat (64) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Result side: random stalls while gaps are on, and once a long hold-off so the input backs up
    initial begin : result_sink
        int unsigned stall;
        int unsigned taken = 0;
        @(posedge aclk);
        forever begin
            if (taken == LONG_HOLD_AT) stall = LONG_HOLD_CYCLES;
            else                       stall = gap_on ? $urandom_range(0, 7) : 0;
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
        end
    end

    initial begin : watchdog
        #200_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
